// ===== rtl/bounded_ordered_job_list_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the ordered job list
// Same-cycle and next-cycle implication checks, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_JOB_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_JOB_LIST_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BOJL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bojl: check failed");

// antecedent implies consequent in the next cycle
`define BOJL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bojl: check failed");

`endif

// ===== rtl/bojl_pkg.sv =====
// ---------------------------------------------------------------------------
// bojl_pkg
// Shared constants, status codes and sequencer states for the job list.
// ---------------------------------------------------------------------------
package bojl_pkg;

  localparam int MaxJobsDef = 16;
  localparam int IdBitsDef  = 16;

  localparam int IdW     = 16;
  localparam int PosW    = 5;
  localparam int CapW    = 5;
  localparam int StatusW = 3;
  localparam int CountW  = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_APPENDED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SEARCH   = 5'b00010,
    S_SHIFT_UP = 5'b00100,
    S_SHIFT_DN = 5'b01000,
    S_FINISH   = 5'b10000
  } state_e;

endpackage

// ===== rtl/bounded_ordered_job_list.sv =====
// One beat at a time: the next beat is taken the cycle after the result loads,
// and a new result loads only once the last one is taken.
// Reset: count cleared, capacity 16, sequencer idle, no result pending; memory kept.
// ---------------------------------------------------------------------------
// bounded_ordered_job_list
// Ordered list of job ids with bounded capacity; insert at position, delete
// by head or by first matching id. Each input beat gives one result beat.
// ---------------------------------------------------------------------------
`include "bounded_ordered_job_list_assert.svh"

module bounded_ordered_job_list import bojl_pkg::*; #(
  parameter int MAX_JOBS = MaxJobsDef,
  parameter int ID_BITS  = IdBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_wr_en_i,
  input  logic [CapW-1:0]     cfg_wr_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [IdW-1:0]      job_id_i,
  input  logic [PosW-1:0]     position_i,
  input  logic                at_tail_i,
  input  logic                take_head_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StatusW-1:0]  status_o,
  output logic [CountW-1:0]   entry_count_o,
  output logic                head_valid_o,
  output logic [IdW-1:0]      head_id_o
);

  // index, count, compare and stored-id widths
  localparam int IW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW   = $clog2(MAX_JOBS + 1);
  localparam int CmpW = (CW > CapW) ? CW : CapW;
  localparam int SW   = (ID_BITS < IdW) ? ID_BITS : IdW;

  localparam logic [CW-1:0] MaxCount = CW'(MAX_JOBS);

  // sequencer and list state
  state_e          state_q, state_d;
  logic [CW-1:0]   occ_q, occ_d;
  logic [CapW-1:0] cap_q;
  status_e         status_q, status_d;

  // item held for the walk
  logic [SW-1:0]   id_q, id_d;
  logic [IW-1:0]   tpos_q, tpos_d;

  // walk control: cnt is the next read index, pa the index read last cycle
  logic [IW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   pa_q, pa_d;
  logic            pend_q, pend_d;
  logic            more_q, more_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  out_status_q;
  logic [CountW-1:0]   out_count_q;
  logic                out_hvalid_q;
  logic [IdW-1:0]      out_head_q;
  logic                out_load;

  // memory port
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [SW-1:0]   wr_data;
  logic [SW-1:0]   rd_data;
  logic [SW-1:0]   head_id;

  logic            in_acc;
  logic [IW-1:0]   last_idx;
  logic [CmpW-1:0] occ_c, pos_c, cap_c;
  logic            list_full;
  logic            pos_past;

  bojl_store #(
    .Depth (MAX_JOBS),
    .DataW (SW),
    .AddrW (IW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (cnt_q),
    .rd_data_o (rd_data),
    .head_o    (head_id)
  );

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign last_idx  = IW'(occ_q - CW'(1));
  assign occ_c     = CmpW'(occ_q);
  assign pos_c     = CmpW'(position_i);
  assign cap_c     = CmpW'(cap_q);
  // capacity above the memory depth is clipped by the second term
  assign list_full = (occ_c >= cap_c) || (occ_q == MaxCount);
  assign pos_past  = (pos_c > occ_c);

  assign out_load  = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  // sequencer: one memory read and at most one write per cycle
  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    status_d = status_q;
    id_d     = id_q;
    tpos_d   = tpos_q;
    cnt_d    = cnt_q;
    pa_d     = pa_q;
    pend_d   = 1'b0;
    more_d   = more_q;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          id_d = SW'(job_id_i);
          if (!action_i) begin
            if (list_full) begin
              status_d = ST_FULL;
              state_d  = S_FINISH;
            end else begin
              tpos_d   = (at_tail_i || pos_past) ? IW'(occ_q) : IW'(position_i);
              status_d = (!at_tail_i && pos_past) ? ST_APPENDED : ST_DONE;
              more_d   = (at_tail_i || pos_past) ? 1'b0 : (IW'(position_i) != IW'(occ_q));
              cnt_d    = last_idx;
              state_d  = S_SHIFT_UP;
            end
          end else begin
            if (occ_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_FINISH;
            end else if (take_head_i) begin
              status_d = ST_DONE;
              cnt_d    = IW'(1);
              more_d   = (occ_q != CW'(1));
              state_d  = S_SHIFT_DN;
            end else begin
              cnt_d   = '0;
              more_d  = 1'b1;
              state_d = S_SEARCH;
            end
          end
        end
      end

      S_SEARCH: begin
        if (more_q) begin
          pend_d = 1'b1;
          pa_d   = cnt_q;
          if (cnt_q == last_idx) begin
            more_d = 1'b0;
          end else begin
            cnt_d = cnt_q + IW'(1);
          end
        end
        if (pend_q) begin
          if (rd_data == id_q) begin
            // first match: close the gap from the entry after it
            status_d = ST_DONE;
            cnt_d    = pa_q + IW'(1);
            more_d   = (pa_q != last_idx);
            pend_d   = 1'b0;
            state_d  = S_SHIFT_DN;
          end else if (pa_q == last_idx) begin
            status_d = ST_NOT_FOUND;
            pend_d   = 1'b0;
            state_d  = S_FINISH;
          end
        end
      end

      S_SHIFT_DN: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pa_q - IW'(1);
          wr_data = rd_data;
        end
        if (more_q) begin
          pend_d = 1'b1;
          pa_d   = cnt_q;
          if (cnt_q == last_idx) begin
            more_d = 1'b0;
          end else begin
            cnt_d = cnt_q + IW'(1);
          end
        end
        if (!more_q && !pend_q) begin
          occ_d   = occ_q - CW'(1);
          state_d = S_FINISH;
        end
      end

      S_SHIFT_UP: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pa_q + IW'(1);
          wr_data = rd_data;
        end
        if (more_q) begin
          pend_d = 1'b1;
          pa_d   = cnt_q;
          if (cnt_q == tpos_q) begin
            more_d = 1'b0;
          end else begin
            cnt_d = cnt_q - IW'(1);
          end
        end
        if (!more_q && !pend_q) begin
          // gap is open at the target slot
          wr_en   = 1'b1;
          wr_addr = tpos_q;
          wr_data = id_q;
          occ_d   = occ_q + CW'(1);
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      cap_q       <= CapReset;
      pend_q      <= 1'b0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      pend_q      <= pend_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        cap_q <= cfg_wr_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    id_q     <= id_d;
    tpos_q   <= tpos_d;
    cnt_q    <= cnt_d;
    pa_q     <= pa_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_count_q  <= CountW'(occ_q);
      out_hvalid_q <= (occ_q != '0);
      out_head_q   <= (occ_q != '0) ? IdW'(head_id) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign head_valid_o  = out_hvalid_q;
  assign head_id_o     = out_head_q;

  // checks
  `BOJL_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= MaxCount)
  `BOJL_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc, state_q != S_IDLE)
  `BOJL_ASSERT_NOW(a_result_from_finish, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_FINISH))

endmodule

// ===== rtl/bojl_store.sv =====
// ---------------------------------------------------------------------------
// bojl_store
// Entry memory: one write port, one registered read port, head mirror.
// ---------------------------------------------------------------------------
module bojl_store import bojl_pkg::*; #(
  parameter int Depth = MaxJobsDef,
  parameter int DataW = IdBitsDef,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  output logic [DataW-1:0] head_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;
  logic [DataW-1:0] head_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  // slot 0 copy, so the head is always on hand without a read
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == '0)) begin
      head_q <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;
  assign head_o    = head_q;

endmodule

// ===== tb/bounded_ordered_job_list_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_ordered_job_list_test
// Self-checking bench for the ordered job list. A directed run covers empty
// and full lists, append past the count, duplicates and zero or lowered
// capacity. Random bursts of add-heavy and delete-heavy beats then follow
// under several capacities and back-pressure mixes. A shadow list predicts
// every result beat, and each beat is checked field by field in order.
// ---------------------------------------------------------------------------
module bounded_ordered_job_list_test;
  import bojl_pkg::*;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_DEL = 1'b1;
  localparam int   NoMatch = -1;

  typedef struct packed {
    logic            action;
    logic [IdW-1:0]  job_id;
    logic [PosW-1:0] position;
    logic            at_tail;
    logic            take_head;
  } job_item_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] entry_count;
    logic              head_valid;
    logic [IdW-1:0]    head_id;
  } job_result_t;

  // every DUT input starts at a known level
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_wr_en_i   = 1'b0;
  logic [CapW-1:0]    cfg_wr_data_i = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               action_i      = 1'b0;
  logic [IdW-1:0]     job_id_i      = '0;
  logic [PosW-1:0]    position_i    = '0;
  logic               at_tail_i     = 1'b0;
  logic               take_head_i   = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  entry_count_o;
  logic               head_valid_o;
  logic [IdW-1:0]     head_id_o;

  // stimulus waiting for the driver, and results still owed by the DUT
  job_item_t   job_requests[$];
  job_result_t predicted_results[$];

  // shadow of the DUT: list contents (index 0 is the head) and capacity
  logic [IdW-1:0]  shadow_jobs[$];
  logic [CapW-1:0] shadow_capacity = CapReset;

  job_item_t   driven_item;
  job_result_t oldest_expected;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_beat_no = 0;

  bounded_ordered_job_list u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .job_id_i      (job_id_i),
    .position_i    (position_i),
    .at_tail_i     (at_tail_i),
    .take_head_i   (take_head_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .head_valid_o  (head_valid_o),
    .head_id_o     (head_id_o)
  );

  // 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Applies one accepted beat to the shadow list and returns the result it
  // should produce. Capacity above the list depth behaves as the depth.
  function automatic job_result_t apply_job_item(input job_item_t it);
    job_result_t r;
    int unsigned eff_cap;
    int unsigned count;
    int          hit;
    eff_cap = (shadow_capacity > MaxJobsDef) ? MaxJobsDef : shadow_capacity;
    count   = shadow_jobs.size();
    hit     = NoMatch;
    if (it.action == ACT_ADD) begin
      // a lowered capacity keeps what is there but blocks further adds
      if (count >= eff_cap) begin
        r.status = ST_FULL;
      end else if (it.at_tail) begin
        shadow_jobs.push_back(it.job_id);
        r.status = ST_DONE;
      end else if (it.position > count) begin
        // past the end: appended, flagged with a warning
        shadow_jobs.push_back(it.job_id);
        r.status = ST_APPENDED;
      end else begin
        shadow_jobs.insert(int'(it.position), it.job_id);
        r.status = ST_DONE;
      end
    end else if (count == 0) begin
      r.status = ST_EMPTY;
    end else if (it.take_head) begin
      void'(shadow_jobs.pop_front());
      r.status = ST_DONE;
    end else begin
      // first match from the head only, so duplicates go one at a time
      foreach (shadow_jobs[i]) begin
        if (hit == NoMatch && shadow_jobs[i] == it.job_id) hit = i;
      end
      if (hit == NoMatch) begin
        r.status = ST_NOT_FOUND;
      end else begin
        shadow_jobs.delete(hit);
        r.status = ST_DONE;
      end
    end
    r.entry_count = CountW'(shadow_jobs.size());
    r.head_valid  = (shadow_jobs.size() != 0);
    r.head_id     = r.head_valid ? shadow_jobs[0] : '0;
    return r;
  endfunction

  // Job ids mostly come from a small pool so that deletes by id find matches;
  // every field is randomised even where the action ignores it.
  function automatic job_item_t random_job_item(input int unsigned add_pct);
    job_item_t it;
    it.action    = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_DEL;
    it.job_id    = ($urandom_range(0, 9) < 7) ? IdW'($urandom_range(0, 15))
                                              : IdW'($urandom_range(0, 65535));
    it.position  = ($urandom_range(0, 7) != 0) ? PosW'($urandom_range(0, 17))
                                               : PosW'($urandom_range(0, 31));
    it.at_tail   = ($urandom_range(0, 3) == 0);
    it.take_head = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    // keep the log bounded if the DUT goes badly wrong
    if (mismatch_count < 100) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string field, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result beat %0d %s got 0x%0h want 0x%0h",
                                result_beat_no, field, got, want));
    end
  endtask

  task automatic push_job(input logic action, input logic [IdW-1:0] id,
                          input logic [PosW-1:0] pos, input logic tail,
                          input logic head);
    job_item_t it;
    it.action    = action;
    it.job_id    = id;
    it.position  = pos;
    it.at_tail   = tail;
    it.take_head = head;
    job_requests.push_back(it);
  endtask

  // Idle means: nothing queued, nothing on the input channel, nothing owed.
  // Checked on the falling edge so the clocked blocks have settled.
  task automatic wait_until_idle();
    do @(negedge clk_i);
    while (job_requests.size() != 0 || in_valid_i || predicted_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    @(posedge clk_i);
    cfg_wr_en_i     <= 1'b1;
    cfg_wr_data_i   <= value;
    shadow_capacity  = value;
    @(posedge clk_i);
    cfg_wr_en_i     <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic start_phase(input logic [CapW-1:0] cap, input int unsigned send_pct,
                             input int unsigned recv_pct);
    wait_until_idle();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_capacity(cap);
  endtask

  // Bursts that are add-heavy or delete-heavy at random fill the list towards
  // capacity and drain it again, so full and empty states both recur.
  task automatic run_random_phase(input logic [CapW-1:0] cap, input int unsigned send_pct,
                                  input int unsigned recv_pct, input int unsigned n_items);
    int unsigned made;
    int unsigned burst;
    int unsigned add_pct;
    start_phase(cap, send_pct, recv_pct);
    made = 0;
    while (made < n_items) begin
      burst   = $urandom_range(8, 24);
      add_pct = $urandom_range(0, 1) ? 88 : 22;
      repeat (burst) begin
        job_requests.push_back(random_job_item(add_pct));
        made++;
      end
    end
  endtask

  // Input driver: a new beat goes out only once the current one is taken;
  // a stalled beat holds its payload. The prediction is made at acceptance.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) predicted_results.push_back(apply_job_item(driven_item));
      if (job_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        driven_item  = job_requests.pop_front();
        action_i    <= driven_item.action;
        job_id_i    <= driven_item.job_id;
        position_i  <= driven_item.position;
        at_tail_i   <= driven_item.at_tail;
        take_head_i <= driven_item.take_head;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor: checks each accepted beat against the oldest prediction
  // and stalls at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected",
                                    result_beat_no));
        end else begin
          oldest_expected = predicted_results.pop_front();
          compare_field("status", status_o, oldest_expected.status);
          compare_field("entry_count", entry_count_o, oldest_expected.entry_count);
          compare_field("head_valid", head_valid_o, oldest_expected.head_valid);
          compare_field("head_id", head_id_o, oldest_expected.head_id);
        end
        result_beat_no++;
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset capacity, sender idles lightly, receiver heavily
    send_idle_pct  = 22;
    recv_stall_pct = 66;
    push_job(ACT_DEL, 16'h0005, 5'd0,  1'b0, 1'b0);  // delete by id, empty
    push_job(ACT_DEL, 16'h0000, 5'd0,  1'b0, 1'b1);  // delete head, empty
    push_job(ACT_ADD, 16'hFFFF, 5'd31, 1'b0, 1'b0);  // past count on empty list
    push_job(ACT_ADD, 16'h0000, 5'd0,  1'b0, 1'b0);  // new head
    push_job(ACT_ADD, 16'h1234, 5'd2,  1'b0, 1'b0);  // position equals count
    push_job(ACT_ADD, 16'h1234, 5'd0,  1'b1, 1'b0);  // tail, duplicate id
    push_job(ACT_ADD, 16'hABCD, 5'd1,  1'b0, 1'b0);  // mid-list insert
    push_job(ACT_ADD, 16'h5555, 5'd6,  1'b0, 1'b0);  // past count, appended
    push_job(ACT_DEL, 16'h1234, 5'd0,  1'b0, 1'b0);  // first duplicate only
    push_job(ACT_DEL, 16'h7777, 5'd0,  1'b0, 1'b0);  // no match
    push_job(ACT_DEL, 16'hFFFF, 5'd31, 1'b1, 1'b1);  // head, id ignored
    push_job(ACT_DEL, 16'h5555, 5'd0,  1'b0, 1'b0);  // remove the tail entry

    // capacity below the current count: entries stay, adds refused
    start_phase(5'd2, 22, 66);
    push_job(ACT_ADD, 16'h0001, 5'd0,  1'b0, 1'b0);
    push_job(ACT_ADD, 16'h0002, 5'd0,  1'b1, 1'b0);
    push_job(ACT_DEL, 16'h0000, 5'd0,  1'b0, 1'b1);
    push_job(ACT_ADD, 16'h0003, 5'd1,  1'b0, 1'b0);  // at the limit
    push_job(ACT_DEL, 16'h1234, 5'd0,  1'b0, 1'b0);
    push_job(ACT_ADD, 16'h00AA, 5'd0,  1'b0, 1'b0);

    // zero capacity rejects every add
    start_phase(5'd0, 22, 66);
    push_job(ACT_ADD, 16'h0004, 5'd0,  1'b0, 1'b0);
    push_job(ACT_ADD, 16'h0005, 5'd16, 1'b1, 1'b0);
    push_job(ACT_DEL, 16'h0000, 5'd0,  1'b0, 1'b1);
    push_job(ACT_DEL, 16'h0000, 5'd0,  1'b0, 1'b1);
    push_job(ACT_DEL, 16'h00AA, 5'd0,  1'b0, 1'b0);  // empty again

    // random: each back-pressure mix under two capacities
    run_random_phase(5'd31, 22, 66, 80);  // above depth, acts as full depth
    run_random_phase(5'd5,  22, 66, 80);
    run_random_phase(5'd16, 66, 22, 80);
    run_random_phase(5'd1,  66, 22, 80);
    run_random_phase(5'd17, 0,  0,  80);
    run_random_phase(5'd9,  0,  0,  80);

    wait_until_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bojl_pkg.sv
rtl/bojl_store.sv
rtl/bounded_ordered_job_list.sv
tb/bounded_ordered_job_list_test.sv
